// ===== rtl/core/lgs_pkg.sv =====
// Shared constants, types and codes for the life generation step block.
// No dependencies; every module of the block refers to it by scoped names.
package lgs_pkg;

  // Grid capacity
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;

  // Fixed field widths
  localparam int CFG_W     = 6;
  localparam int OPC_W     = 2;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int COL_SEL_W = $clog2(MAX_WIDTH);
  localparam int ROW_SEL_W = $clog2(MAX_HEIGHT);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);

  // B3/S23 rule
  localparam int CNT_W       = 4;
  localparam int SURVIVE_LOW = 2;
  localparam int BIRTH_COUNT = 3;

  // Register reset values
  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = CFG_W'(18);
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = CFG_W'(18);

  // Opcodes
  localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPC_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef logic [MAX_WIDTH-1:0] row_t;

  typedef enum logic {
    ST_IDLE,
    ST_GEN
  } state_t;

  // Control shared by every row cell of the chain
  typedef struct packed {
    logic                 shift;
    logic [COL_SEL_W-1:0] wr_col;
    logic                 wr_bit;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/life_generation_step.sv =====
// Top level of the life generation step block: row-cell chain, rule unit, control.
// Depends on lgs_pkg, lgs_row_cell and lgs_rule_unit.
//
// Usage
//   Input channel (in_*): one word per command. Opcode write sets one cell, read
//   returns one cell, step advances the whole grid one generation (B3/S23, dead
//   beyond the configured edge). Every word gives exactly one result word on out_*.
//   Config channel (cfg_*): index 0 grid_width, index 1 grid_height, always ready;
//   write only while the block is idle.
// Timing
//   Read, write and unused opcodes: result registered one cycle after acceptance;
//   a new word can be taken every cycle while the receiver keeps up.
//   Step: the grid rows rotate once round the chain of MAX_HEIGHT row cells, one
//   row through the rule unit per cycle; the result is registered by
//   the edge of the last shift and the following word is taken from then on.
// Reset
//   rst_n (synchronous) clears every cell at once and loads 18 by 18.
// Stall
//   A result held by a low out_ready holds the output register; no further word
//   is then taken until that result has gone.
module life_generation_step (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lgs_pkg::OPC_W-1:0]       in_opcode,
  input  logic [lgs_pkg::IDX_W-1:0]       in_row_index,
  input  logic [lgs_pkg::IDX_W-1:0]       in_col_index,
  input  logic                            in_cell_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_read_value,
  output logic                            out_index_error,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]       cfg_data
);

  localparam int MH = lgs_pkg::MAX_HEIGHT;

  // configuration registers
  logic [lgs_pkg::CFG_W-1:0] grid_width_r, grid_width_nxt;
  logic [lgs_pkg::CFG_W-1:0] grid_height_r, grid_height_nxt;

  // control
  lgs_pkg::state_t               state_r, state_nxt;
  logic [lgs_pkg::ROW_SEL_W-1:0] step_r, step_nxt;
  lgs_pkg::row_t                 above_r, above_nxt;
  logic                          shift_en;
  logic                          gen_last;
  logic                          accept;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_read_value_r, out_read_value_nxt;
  logic out_index_error_r, out_index_error_nxt;

  // datapath
  logic [lgs_pkg::WID_W-1:0] width_used;
  logic [lgs_pkg::HGT_W-1:0] height_used;
  lgs_pkg::row_t             col_mask;
  lgs_pkg::row_t             rows [MH];
  lgs_pkg::row_t             cur_masked, below_masked, next_raw, new_row;
  logic                      cur_live, below_live;
  logic                      in_range;
  logic                      rd_bit;
  logic [MH-1:0]             wr_en;
  lgs_pkg::cell_ctrl_t       cell_ctrl;
  logic                      res_rd, res_err;

  // config writes
  assign cfg_ready = 1'b1;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lgs_pkg::REG_GRID_WIDTH:  grid_width_nxt  = cfg_data;
        lgs_pkg::REG_GRID_HEIGHT: grid_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lgs_pkg::GRID_WIDTH_RST;
      grid_height_r <= lgs_pkg::GRID_HEIGHT_RST;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  // size in use, clamped to capacity
  assign width_used  = (int'(grid_width_r) > lgs_pkg::MAX_WIDTH) ?
                       lgs_pkg::WID_W'(lgs_pkg::MAX_WIDTH) :
                       lgs_pkg::WID_W'(grid_width_r);
  assign height_used = (int'(grid_height_r) > lgs_pkg::MAX_HEIGHT) ?
                       lgs_pkg::HGT_W'(lgs_pkg::MAX_HEIGHT) :
                       lgs_pkg::HGT_W'(grid_height_r);

  always_comb begin
    for (int c = 0; c < lgs_pkg::MAX_WIDTH; c++) begin
      col_mask[c] = (c < int'(width_used));
    end
  end

  assign in_range = (int'(in_row_index) < int'(height_used)) &&
                    (int'(in_col_index) < int'(width_used));

  // single-cell read
  assign rd_bit = rows[lgs_pkg::ROW_SEL_W'(in_row_index)][lgs_pkg::COL_SEL_W'(in_col_index)];

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lgs_pkg::ST_IDLE: begin
        if (accept && (in_opcode == lgs_pkg::OP_STEP)) state_nxt = lgs_pkg::ST_GEN;
      end
      lgs_pkg::ST_GEN: begin
        if (gen_last) state_nxt = lgs_pkg::ST_IDLE;
      end
      default: state_nxt = lgs_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    gen_last = 1'b0;
    case (state_r)
      lgs_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      lgs_pkg::ST_GEN: begin
        shift_en = 1'b1;
        gen_last = (step_r == lgs_pkg::ROW_SEL_W'(MH - 1));
      end
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lgs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sweep counter
  always_comb begin
    step_nxt = step_r;
    if (shift_en) begin
      step_nxt = step_r + 1'b1;
    end else if (accept) begin
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  // row above the head: last processed old row, dead at the top edge
  always_comb begin
    above_nxt = above_r;
    if (shift_en) begin
      above_nxt = cur_masked;
    end else if (accept) begin
      above_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    above_r <= above_nxt;
  end

  // head of the chain feeds the rule unit
  assign cur_live     = (int'(step_r) < int'(height_used));
  assign below_live   = (int'(step_r) + 1 < int'(height_used));
  assign cur_masked   = rows[0] & col_mask & {lgs_pkg::MAX_WIDTH{cur_live}};
  assign below_masked = rows[1] & col_mask & {lgs_pkg::MAX_WIDTH{below_live}};

  lgs_rule_unit u_rule (
    .above    (above_r),
    .cur      (cur_masked),
    .below    (below_masked),
    .next_row (next_raw)
  );

  assign new_row = next_raw & col_mask & {lgs_pkg::MAX_WIDTH{cur_live}};

  // chain of row cells; new rows enter at the tail
  assign cell_ctrl.shift  = shift_en;
  assign cell_ctrl.wr_col = lgs_pkg::COL_SEL_W'(in_col_index);
  assign cell_ctrl.wr_bit = in_cell_value;

  for (genvar i = 0; i < MH; i++) begin : g_row
    assign wr_en[i] = accept && (in_opcode == lgs_pkg::OP_WRITE) && in_range &&
                      (lgs_pkg::ROW_SEL_W'(in_row_index) == lgs_pkg::ROW_SEL_W'(i));
    if (i == MH - 1) begin : g_tail
      lgs_row_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .wr_en    (wr_en[i]),
        .shift_in (new_row),
        .row      (rows[i])
      );
    end else begin : g_body
      lgs_row_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .wr_en    (wr_en[i]),
        .shift_in (rows[i+1]),
        .row      (rows[i])
      );
    end
  end

  // result word for read, write and unused opcodes
  always_comb begin
    res_rd  = 1'b0;
    res_err = 1'b0;
    case (in_opcode)
      lgs_pkg::OP_WRITE: res_err = !in_range;
      lgs_pkg::OP_READ: begin
        res_err = !in_range;
        res_rd  = in_range && rd_bit;
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt       = out_valid_r;
    out_read_value_nxt  = out_read_value_r;
    out_index_error_nxt = out_index_error_r;
    if (accept && (in_opcode != lgs_pkg::OP_STEP)) begin
      out_valid_nxt       = 1'b1;
      out_read_value_nxt  = res_rd;
      out_index_error_nxt = res_err;
    end else if (gen_last) begin
      out_valid_nxt       = 1'b1;
      out_read_value_nxt  = 1'b0;
      out_index_error_nxt = 1'b0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_read_value_r  <= out_read_value_nxt;
    out_index_error_r <= out_index_error_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_index_error = out_index_error_r;

  // checks
  a_gen_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == lgs_pkg::OP_STEP) |=> (state_r == lgs_pkg::ST_GEN) && (step_r == '0))
    else $error("step word did not start a sweep");

  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgs_pkg::ST_GEN) |-> !out_valid_r)
    else $error("result pending during a sweep");

  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgs_pkg::ST_GEN) && !gen_last |=> step_r == $past(step_r) + 1'b1)
    else $error("sweep counter skipped");

  a_gen_result: assert property (@(posedge clk) disable iff (!rst_n)
    gen_last |=> out_valid_r && !out_read_value_r && !out_index_error_r &&
                 (state_r == lgs_pkg::ST_IDLE))
    else $error("bad result at end of sweep");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_index_error_r |-> !out_read_value_r)
    else $error("read value with index error");

endmodule

// ===== rtl/core/lgs_row_cell.sv =====
// One row cell of the grid chain: holds a full row of cells.
// Depends on lgs_pkg. Shifts in its lower neighbour's row or takes a single-bit write.
module lgs_row_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lgs_pkg::cell_ctrl_t ctrl,
  input  logic               wr_en,
  input  lgs_pkg::row_t      shift_in,
  output lgs_pkg::row_t      row
);

  lgs_pkg::row_t row_r;
  lgs_pkg::row_t row_nxt;

  // shift during a generation sweep, else single-cell write
  always_comb begin
    row_nxt = row_r;
    if (ctrl.shift) begin
      row_nxt = shift_in;
    end else if (wr_en) begin
      row_nxt[ctrl.wr_col] = ctrl.wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row = row_r;

endmodule

// ===== rtl/core/lgs_rule_unit.sv =====
// B3/S23 rule applied across one row, one lane per column.
// Depends on lgs_pkg. Inputs are pre-masked rows; columns past the edge read as dead.
module lgs_rule_unit (
  input  lgs_pkg::row_t above,
  input  lgs_pkg::row_t cur,
  input  lgs_pkg::row_t below,
  output lgs_pkg::row_t next_row
);

  // neighbour rows shifted so bit c sees column c-1 / c+1
  lgs_pkg::row_t above_l, above_rt, cur_l, cur_rt, below_l, below_rt;

  assign above_l  = above << 1;
  assign above_rt = above >> 1;
  assign cur_l    = cur << 1;
  assign cur_rt   = cur >> 1;
  assign below_l  = below << 1;
  assign below_rt = below >> 1;

  // per-lane live neighbour count and rule
  always_comb begin
    logic [lgs_pkg::CNT_W-1:0] n;
    next_row = '0;
    for (int c = 0; c < lgs_pkg::MAX_WIDTH; c++) begin
      n = lgs_pkg::CNT_W'(above_l[c]) + lgs_pkg::CNT_W'(above[c]) +
          lgs_pkg::CNT_W'(above_rt[c]) + lgs_pkg::CNT_W'(cur_l[c]) +
          lgs_pkg::CNT_W'(cur_rt[c]) + lgs_pkg::CNT_W'(below_l[c]) +
          lgs_pkg::CNT_W'(below[c]) + lgs_pkg::CNT_W'(below_rt[c]);
      if (cur[c]) begin
        next_row[c] = (n == lgs_pkg::CNT_W'(lgs_pkg::SURVIVE_LOW)) ||
                      (n == lgs_pkg::CNT_W'(lgs_pkg::BIRTH_COUNT));
      end else begin
        next_row[c] = (n == lgs_pkg::CNT_W'(lgs_pkg::BIRTH_COUNT));
      end
    end
  end

endmodule
